>>> rtl/mffd_pkg.sv
// Shared types and constants for the maze flood-fill distance core.
// Depends on nothing; imported by the map store, the sequencer and the top level.
package mffd_pkg;

	localparam int COORD_W = 4;
	localparam int CELL_W  = 8;
	localparam int CELLS   = 256;
	localparam int DIST_W  = 8;
	localparam int WALL_W  = 4;
	localparam int PTR_W   = 9;

	localparam logic [DIST_W-1:0] UNREACHED = 8'd255;

	localparam logic [0:0] REG_GOAL_X = 1'b0;
	localparam logic [0:0] REG_GOAL_Y = 1'b1;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic                wall_we;
		logic [CELL_W-1:0]   wall_waddr;
		logic [WALL_W-1:0]   wall_wdata;
		logic [CELL_W-1:0]   wall_raddr;
		logic                dist_we;
		logic [CELL_W-1:0]   dist_waddr;
		logic [DIST_W-1:0]   dist_wdata;
		logic [CELL_W-1:0]   dist_raddr;
		logic                q_we;
		logic [CELL_W-1:0]   q_waddr;
		logic [CELL_W-1:0]   q_wdata;
		logic [CELL_W-1:0]   q_raddr;
	} mffd_mem_req_t;

	typedef struct packed {
		logic [WALL_W-1:0]   wall;
		logic [DIST_W-1:0]   dist_rd;
		logic [CELL_W-1:0]   qcell;
	} mffd_mem_rsp_t;

	function automatic logic [WALL_W-1:0] side_mask(input logic [1:0] dir);
		side_mask = 4'b0001 << dir;
	endfunction

endpackage

>>> rtl/mffd_maps.sv
// Wall map, distance map and visit queue memories with registered reads.
// Depends on mffd_pkg; unwritten wall entries read as the border walls.
module mffd_maps #(
	parameter int GRID_SIDE = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mffd_pkg::mffd_mem_req_t req,
	output mffd_pkg::mffd_mem_rsp_t rsp
);
	import mffd_pkg::*;

	logic [WALL_W-1:0] wall_mem [CELLS];
	logic [DIST_W-1:0] dist_mem [CELLS];
	logic [CELL_W-1:0] q_mem    [CELLS];
	logic [CELLS-1:0]  wall_vld_q;

	logic [WALL_W-1:0] wall_rd_s1;
	logic              wall_vld_s1;
	logic [CELL_W-1:0] wall_addr_s1;
	logic [DIST_W-1:0] dist_rd_s1;
	logic [CELL_W-1:0] q_rd_s1;

	logic [COORD_W-1:0] bx;
	logic [COORD_W-1:0] by;
	logic [WALL_W-1:0]  border;

	always_ff @(posedge clk) begin
		if (req.wall_we) begin
			wall_mem[req.wall_waddr] <= req.wall_wdata;
		end
		if (req.dist_we) begin
			dist_mem[req.dist_waddr] <= req.dist_wdata;
		end
		if (req.q_we) begin
			q_mem[req.q_waddr] <= req.q_wdata;
		end
		wall_rd_s1   <= wall_mem[req.wall_raddr];
		wall_addr_s1 <= req.wall_raddr;
		dist_rd_s1   <= dist_mem[req.dist_raddr];
		q_rd_s1      <= q_mem[req.q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_vld_q  <= '0;
			wall_vld_s1 <= 1'b0;
		end else begin
			if (req.wall_we) begin
				wall_vld_q[req.wall_waddr] <= 1'b1;
			end
			wall_vld_s1 <= wall_vld_q[req.wall_raddr];
		end
	end

	always_comb begin
		bx = wall_addr_s1[CELL_W-1:COORD_W];
		by = wall_addr_s1[COORD_W-1:0];
		border = '0;
		if ({1'b0, by} == 5'(GRID_SIDE - 1)) border = border | side_mask(DIR_N);
		if ({1'b0, bx} == 5'(GRID_SIDE - 1)) border = border | side_mask(DIR_E);
		if (by == '0) border = border | side_mask(DIR_S);
		if (bx == '0) border = border | side_mask(DIR_W);
	end

	assign rsp.wall    = wall_vld_s1 ? wall_rd_s1 : border;
	assign rsp.dist_rd = dist_rd_s1;
	assign rsp.qcell   = q_rd_s1;

endmodule

>>> rtl/mffd_seq.sv
// Request sequencer: wall update, distance clear, goal seeding, queue-driven flood fill
// and result lookup. Depends on mffd_pkg; drives the memories in mffd_maps.
module mffd_seq #(
	parameter int GRID_SIDE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,
	input  logic [mffd_pkg::COORD_W-1:0]   goal_x,
	input  logic [mffd_pkg::COORD_W-1:0]   goal_y,
	output mffd_pkg::mffd_mem_req_t        req,
	input  mffd_pkg::mffd_mem_rsp_t        rsp
);
	import mffd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_WRD, S_WWR, S_CLR, S_SEED, S_POP, S_FETCH, S_SRC, S_NB, S_LOOK, S_DONE
	} state_t;

	state_t             state_q;
	logic [CELL_W-1:0]  cell_q;
	logic               here_q;
	logic [WALL_W-1:0]  add_q;
	logic [CELL_W-1:0]  cnt_q;
	logic [1:0]         seed_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CELL_W-1:0]  cur_q;
	logic [PTR_W-1:0]   next_q;
	logic [WALL_W-1:0]  wall_q;
	logic [2:0]         k_q;
	logic               chk_v_s1;
	logic [CELL_W-1:0]  chk_n_s1;
	logic               dist_ok_q;
	logic               m_tvalid_q;
	logic [DIST_W-1:0]  m_tdata_q;

	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [1:0]         in_h;
	logic               in_here;
	logic [WALL_W-1:0]  in_add;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic               nb_ok;
	logic [CELL_W-1:0]  nb_cell;
	logic [4:0]         gx5;
	logic [4:0]         gy5;
	logic               seed_in;
	logic               improve;
	logic               accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		in_x    = s_tdata[3:0];
		in_y    = s_tdata[7:4];
		in_h    = s_tdata[9:8];
		in_here = ({1'b0, in_x} < 5'(GRID_SIDE)) && ({1'b0, in_y} < 5'(GRID_SIDE));
		in_add  = '0;
		if (s_tdata[10]) in_add = in_add | side_mask(in_h + 2'd3);
		if (s_tdata[11]) in_add = in_add | side_mask(in_h);
		if (s_tdata[12]) in_add = in_add | side_mask(in_h + 2'd1);
	end

	always_comb begin
		cx      = cur_q[CELL_W-1:COORD_W];
		cy      = cur_q[COORD_W-1:0];
		nb_ok   = 1'b0;
		nb_cell = cur_q;
		case (k_q[1:0])
			DIR_N: begin
				nb_ok   = {1'b0, cy} < 5'(GRID_SIDE - 1);
				nb_cell = {cx, cy + 4'd1};
			end
			DIR_E: begin
				nb_ok   = {1'b0, cx} < 5'(GRID_SIDE - 1);
				nb_cell = {cx + 4'd1, cy};
			end
			DIR_S: begin
				nb_ok   = (cy != '0);
				nb_cell = {cx, cy - 4'd1};
			end
			DIR_W: begin
				nb_ok   = (cx != '0);
				nb_cell = {cx - 4'd1, cy};
			end
			default: begin
				nb_ok   = 1'b0;
				nb_cell = cur_q;
			end
		endcase
		nb_ok = nb_ok && !wall_q[k_q[1:0]] && !k_q[2];
	end

	always_comb begin
		gx5     = {1'b0, goal_x} + {4'd0, seed_q[1]};
		gy5     = {1'b0, goal_y} + {4'd0, seed_q[0]};
		seed_in = (gx5 < 5'(GRID_SIDE)) && (gy5 < 5'(GRID_SIDE));
		improve = chk_v_s1 && ({1'b0, rsp.dist_rd} > next_q);
	end

	always_comb begin
		req            = '0;
		req.wall_raddr = cell_q;
		req.wall_waddr = cell_q;
		req.wall_wdata = rsp.wall | add_q;
		req.dist_raddr = cell_q;
		req.q_raddr    = head_q[CELL_W-1:0];
		req.q_waddr    = tail_q[CELL_W-1:0];
		case (state_q)
			S_WWR: begin
				req.wall_we = 1'b1;
			end
			S_CLR: begin
				req.dist_we    = 1'b1;
				req.dist_waddr = cnt_q;
				req.dist_wdata = UNREACHED;
			end
			S_SEED: begin
				req.dist_we    = seed_in;
				req.dist_waddr = {gx5[3:0], gy5[3:0]};
				req.dist_wdata = '0;
				req.q_we       = seed_in;
				req.q_wdata    = {gx5[3:0], gy5[3:0]};
			end
			S_FETCH: begin
				req.wall_raddr = rsp.qcell;
				req.dist_raddr = rsp.qcell;
			end
			S_NB: begin
				req.dist_raddr = nb_cell;
				req.dist_we    = improve;
				req.dist_waddr = chk_n_s1;
				req.dist_wdata = next_q[DIST_W-1:0];
				req.q_we       = improve;
				req.q_wdata    = chk_n_s1;
			end
			default: begin
				req.wall_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cell_q     <= '0;
			here_q     <= 1'b0;
			add_q      <= '0;
			cnt_q      <= '0;
			seed_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cur_q      <= '0;
			next_q     <= '0;
			wall_q     <= '0;
			k_q        <= '0;
			chk_v_s1   <= 1'b0;
			chk_n_s1   <= '0;
			dist_ok_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			if (req.q_we) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cell_q <= {in_x, in_y};
						here_q <= in_here;
						add_q  <= in_add;
						cnt_q  <= '0;
						if (s_tuser) begin
							state_q <= S_LOOK;
						end else if (in_here) begin
							state_q <= S_WRD;
						end else begin
							state_q <= S_CLR;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WWR;
				end
				S_WWR: begin
					state_q <= S_CLR;
				end
				S_CLR: begin
					cnt_q     <= cnt_q + CELL_W'(1);
					head_q    <= '0;
					tail_q    <= '0;
					seed_q    <= '0;
					dist_ok_q <= 1'b1;
					if (cnt_q == CELL_W'(CELLS - 1)) begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					seed_q <= seed_q + 2'd1;
					if (seed_q == 2'd3) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_LOOK;
					end else begin
						head_q  <= head_q + PTR_W'(1);
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					cur_q   <= rsp.qcell;
					state_q <= S_SRC;
				end
				S_SRC: begin
					next_q   <= {1'b0, rsp.dist_rd} + PTR_W'(1);
					wall_q   <= rsp.wall;
					k_q      <= '0;
					chk_v_s1 <= 1'b0;
					state_q  <= S_NB;
				end
				S_NB: begin
					chk_v_s1 <= nb_ok;
					chk_n_s1 <= nb_cell;
					k_q      <= k_q + 3'd1;
					if (k_q[2]) begin
						state_q <= S_POP;
					end
				end
				S_LOOK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= (here_q && dist_ok_q) ? rsp.dist_rd : UNREACHED;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/maze_flood_fill_distance_core.sv
// Maze flood-fill distance core: goal registers, sequencer and map memories.
// Depends on mffd_pkg, mffd_seq and mffd_maps.
//
// Usage: requests arrive on the s_ channel (s_tuser = op: 0 sense walls and refill,
// 1 read only). Each request returns one distance on the m_ channel, 255 if the
// cell is unreached or outside the grid. The goal corner is written through
// cfg_wen/cfg_idx/cfg_wdata while no request is in flight.
// One request is processed at a time; s_tready is high only while idle.
// A read request reads the distance map in S_LOOK; S_DONE registers the result.
// A sense request runs the wall update, the distance clear over all 256 cells and
// goal seeding, then the fill, in which each reached cell needs one queue pop, one
// source read and five neighbor slots on the single distance-map read port.
// After reset the wall map holds the border walls, every distance reads 255 and
// the goal corner is (7, 7). A stalled result waits in the output register; the
// core holds its finished request until that register is free.
module maze_flood_fill_distance_core #(
	parameter int GRID_SIDE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cell_x[3:0], cell_y[7:4], heading[9:8],
	                              // wall_left[10], wall_front[11], wall_right[12]
	input  logic        s_tuser,  // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // distance[7:0]
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_idx,
	input  logic [3:0]  cfg_wdata
);
	import mffd_pkg::*;

	logic [COORD_W-1:0] goal_x_q;
	logic [COORD_W-1:0] goal_y_q;
	mffd_mem_req_t      req;
	mffd_mem_rsp_t      rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= 4'd7;
			goal_y_q <= 4'd7;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_GOAL_X: goal_x_q <= cfg_wdata;
				REG_GOAL_Y: goal_y_q <= cfg_wdata;
				default:    goal_x_q <= goal_x_q;
			endcase
		end
	end

	mffd_seq #(
		.GRID_SIDE(GRID_SIDE)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.goal_x  (goal_x_q),
		.goal_y  (goal_y_q),
		.req     (req),
		.rsp     (rsp)
	);

	mffd_maps #(
		.GRID_SIDE(GRID_SIDE)
	) u_maps (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

>>> rtl/mffd_chk.sv
// Port-level checker for the maze flood-fill distance core, bound to the top level.
// Depends only on the top-level ports.
module mffd_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
			pend_q <= pend_q + 2'd1;
		end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (pend_q != 2'd0))
		else $error("result without request");

	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && (pend_q != 2'd0)) |-> m_tvalid)
		else $error("ready again before result was shown");

endmodule

bind maze_flood_fill_distance_core mffd_chk u_mffd_chk (.*);

>>> bench/testbench.sv
// Self-checking bench for maze_flood_fill_distance_core: directed and random requests,
// a distance predictor with its own wall and distance maps, and a result scoreboard.
// Depends on mffd_pkg and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mffd_pkg::*;

	localparam logic OP_SENSE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [3:0] x;
		logic [3:0] y;
		logic [1:0] heading;
		logic       left;
		logic       front;
		logic       right;
	} maze_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // cell_x[3:0], cell_y[7:4], heading[9:8],
	                            // wall_left[10], wall_front[11], wall_right[12]
	logic        s_tuser = 1'b0;  // op[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // distance[7:0]
	logic        cfg_wen = 1'b0;
	logic [0:0]  cfg_idx = REG_GOAL_X;
	logic [3:0]  cfg_wdata = '0;

	logic [3:0]  wall_map [CELLS];
	logic [7:0]  dist_map [CELLS];
	logic [3:0]  goal_x;
	logic [3:0]  goal_y;
	logic [7:0]  dist_expect [$];
	int          mismatches = 0;
	int          sender_idle_pct = 17;
	int          receiver_idle_pct = 48;
	int          receiver_hold_cycles = 0;

	maze_flood_fill_distance_core #(.GRID_SIDE(16)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void reset_maps();
		for (int x = 0; x < 16; x++) begin
			for (int y = 0; y < 16; y++) begin
				wall_map[x*16+y] = {x == 0, y == 0, x == 15, y == 15};
				dist_map[x*16+y] = UNREACHED;
			end
		end
		goal_x = 4'd7;
		goal_y = 4'd7;
	endfunction

	function automatic void refill_distances();
		logic [7:0] visit [CELLS];
		int head;
		int tail;
		int gx;
		int gy;
		int x;
		int y;
		int nx;
		int ny;
		int step;
		logic [7:0] c;
		logic [7:0] n;
		head = 0;
		tail = 0;
		for (int i = 0; i < CELLS; i++)
			dist_map[i] = UNREACHED;
		for (int dx = 0; dx < 2; dx++) begin
			for (int dy = 0; dy < 2; dy++) begin
				gx = int'(goal_x) + dx;
				gy = int'(goal_y) + dy;
				if (gx < 16 && gy < 16) begin
					c = {gx[3:0], gy[3:0]};
					dist_map[c] = 8'd0;
					visit[tail] = c;
					tail++;
				end
			end
		end
		while (head < tail) begin
			c = visit[head];
			head++;
			x = int'(c[7:4]);
			y = int'(c[3:0]);
			step = int'(dist_map[c]) + 1;
			for (int d = 0; d < 4; d++) begin
				nx = x;
				ny = y;
				case (d[1:0])
					DIR_N: ny = y + 1;
					DIR_E: nx = x + 1;
					DIR_S: ny = y - 1;
					DIR_W: nx = x - 1;
				endcase
				if (nx < 0 || nx > 15 || ny < 0 || ny > 15 || wall_map[c][d])
					continue;
				n = {nx[3:0], ny[3:0]};
				if (int'(dist_map[n]) > step) begin
					dist_map[n] = step[7:0];
					visit[tail] = n;
					tail++;
				end
			end
		end
	endfunction

	function automatic logic [7:0] predict_distance(maze_request_t rq);
		logic [3:0] add;
		add = '0;
		if (rq.op == OP_SENSE) begin
			if (rq.left)
				add[rq.heading + 2'd3] = 1'b1;
			if (rq.front)
				add[rq.heading] = 1'b1;
			if (rq.right)
				add[rq.heading + 2'd1] = 1'b1;
			wall_map[{rq.x, rq.y}] = wall_map[{rq.x, rq.y}] | add;
			refill_distances();
		end
		return dist_map[{rq.x, rq.y}];
	endfunction

	function automatic maze_request_t request(logic op, int x, int y, logic [1:0] heading,
			logic left, logic front, logic right);
		return '{op, x[3:0], y[3:0], heading, left, front, right};
	endfunction

	function automatic maze_request_t random_request(int sense_pct, int wall_pct);
		maze_request_t rq;
		rq.op      = ($urandom_range(99) < sense_pct) ? OP_SENSE : OP_READ;
		rq.x       = 4'($urandom_range(15));
		rq.y       = 4'($urandom_range(15));
		rq.heading = 2'($urandom_range(3));
		rq.left    = $urandom_range(99) < wall_pct;
		rq.front   = $urandom_range(99) < wall_pct;
		rq.right   = $urandom_range(99) < wall_pct;
		return rq;
	endfunction

	task automatic send_request(maze_request_t rq);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.op;
		s_tdata  <= {3'b000, rq.right, rq.front, rq.left, rq.heading, rq.y, rq.x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		dist_expect.push_back(predict_distance(rq));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (dist_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_goal(logic [3:0] x, logic [3:0] y);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_GOAL_X;
		cfg_wdata <= x;
		@(posedge clk);
		cfg_idx   <= REG_GOAL_Y;
		cfg_wdata <= y;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		goal_x = x;
		goal_y = y;
	endtask

	always @(posedge clk) begin : result_check
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_expect.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected distance expected none actual %0d", $time, m_tdata);
			end else begin
				want = dist_expect.pop_front();
				if (m_tdata !== want) begin
					mismatches++;
					$display("%0t: distance expected %0d actual %0d", $time, want, m_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (receiver_hold_cycles > 0) begin
			receiver_hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= receiver_idle_pct;
		end
	end

	task automatic test_reset_distances();
		send_request(request(OP_READ, 0, 0, DIR_N, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_READ, 15, 15, DIR_W, 1'b1, 1'b1, 1'b1));
		send_request(request(OP_READ, 7, 7, DIR_S, 1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_sense_headings();
		send_request(request(OP_SENSE, 6, 7, DIR_N, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_SENSE, 0, 15, DIR_N, 1'b1, 1'b1, 1'b1));
		send_request(request(OP_SENSE, 15, 0, DIR_E, 1'b1, 1'b0, 1'b0));
		send_request(request(OP_SENSE, 3, 12, DIR_S, 1'b0, 1'b1, 1'b0));
		send_request(request(OP_SENSE, 12, 3, DIR_W, 1'b0, 1'b0, 1'b1));
		send_request(request(OP_SENSE, 8, 8, DIR_S, 1'b1, 1'b1, 1'b1));
		send_request(request(OP_READ, 0, 0, DIR_N, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_READ, 15, 15, DIR_N, 1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_goal_corners();
		set_goal(4'd0, 4'd0);
		send_request(request(OP_READ, 0, 0, DIR_N, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_SENSE, 1, 1, DIR_E, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_READ, 15, 15, DIR_N, 1'b0, 1'b0, 1'b0));
		set_goal(4'd14, 4'd14);
		send_request(request(OP_SENSE, 14, 15, DIR_W, 1'b0, 1'b1, 1'b0));
		send_request(request(OP_READ, 0, 0, DIR_N, 1'b0, 1'b0, 1'b0));
		set_goal(4'd15, 4'd15);
		send_request(request(OP_SENSE, 15, 15, DIR_N, 1'b0, 1'b0, 1'b0));
		send_request(request(OP_READ, 14, 14, DIR_N, 1'b0, 1'b0, 1'b0));
		set_goal(4'd15, 4'd3);
		send_request(request(OP_SENSE, 15, 4, DIR_S, 1'b1, 1'b0, 1'b1));
		send_request(request(OP_READ, 0, 3, DIR_N, 1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_output_stall();
		set_goal(4'd7, 4'd7);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		receiver_hold_cycles = 400;
		repeat (20)
			send_request(random_request(10, 30));
		drain_results();
		repeat (4)
			send_request(random_request(50, 30));
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 3; phase++) begin
			set_goal(4'($urandom_range(15)), 4'($urandom_range(15)));
			sender_idle_pct   = (phase == 0) ? 17 : (phase == 1) ? 48 : 0;
			receiver_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 17 : 0;
			repeat (125)
				send_request(random_request(40, 30));
		end
	endtask

	initial begin
		reset_maps();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_distances();
		test_sense_headings();
		test_goal_corners();
		test_output_stall();
		test_random_phases();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
rtl/mffd_pkg.sv
rtl/mffd_maps.sv
rtl/mffd_seq.sv
rtl/maze_flood_fill_distance_core.sv
rtl/mffd_chk.sv
bench/testbench.sv
